// ===== hw/rtl/prad_pkg.sv =====
// Shared types, codes and helpers of the page region address decoder.
// Used by every module of the block; depends on nothing.
package prad_pkg;

    localparam int PAGE_COUNT_DEF    = 256;
    localparam int HANDLER_SLOTS_DEF = 32;
    localparam int ENTRY_W           = 45;
    localparam int HID_W             = 5;
    localparam int PAGE_FIELD_W      = 8;
    localparam int PAGE_SHIFT        = 24;
    localparam int QUEUE_DEPTH       = 2;
    localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFF;
    localparam logic [1:0]  SIZE_4B   = 2'd2;
    localparam logic [1:0]  SIZE_8B   = 2'd3;

    typedef enum logic [1:0] {
        CMD_ACCESS      = 2'd0,
        CMD_MAP_HANDLER = 2'd1,
        CMD_MAP_BLOCK   = 2'd2,
        CMD_MIRROR      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_RANGE = 3'd1,
        ST_BAD_MASK  = 3'd2,
        ST_BAD_BASE  = 3'd3,
        ST_OVERLAP   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_ACCESS,
        OP_FILL,
        OP_MIRROR,
        OP_REPORT
    } op_kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_EMIT2,
        B_FILL,
        B_MREAD,
        B_MWRITE,
        B_DONE
    } back_state_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [31:0]              addr;
        logic [1:0]               size_code;
        logic                     is_write;
        logic [63:0]              write_data;
        logic [PAGE_FIELD_W-1:0]  start_page;
        logic [PAGE_FIELD_W-1:0]  end_page;
        logic [8:0]               region_pages;
        logic [PAGE_FIELD_W-1:0]  dest_page;
        logic [HID_W-1:0]         handler_num;
        logic [47:0]              block_base;
        logic [31:0]              block_mask;
    } req_t;

    typedef struct packed {
        op_kind_t                 kind;
        logic [31:0]              addr;
        logic [1:0]               size_code;
        logic                     is_write;
        logic [63:0]              write_data;
        logic [PAGE_FIELD_W-1:0]  page;
        logic [PAGE_FIELD_W-1:0]  last_page;
        logic [PAGE_FIELD_W-1:0]  dest;
        logic [8:0]               count;
        logic [ENTRY_W-1:0]       entry;
        status_t                  status;
    } op_t;

    typedef struct packed {
        logic                     to_memory;
        logic [47:0]              host_address;
        logic [HID_W-1:0]         route_handler;
        logic [31:0]              handler_address;
        logic [1:0]               handler_size;
        logic                     access_write;
        logic [63:0]              piece_data;
        logic                     last;
        status_t                  status;
    } res_t;

    // Shift k with mask == all-ones >> k, or 32 when the mask has no such form.
    function automatic logic [5:0] mask_shift(input logic [31:0] mask);
        logic [5:0] k;
        k = 6'd32;
        for (int i = 31; i >= 0; i--) begin
            if (mask == (WORD_MASK >> i)) begin
                k = 6'(i);
            end
        end
        return k;
    endfunction

endpackage

// ===== hw/rtl/prad_front.sv =====
// Front part: classifies one request into a decoded operation and runs the checks.
// Depends on prad_pkg.
module prad_front #(
    parameter int PAGE_COUNT    = prad_pkg::PAGE_COUNT_DEF,
    parameter int HANDLER_SLOTS = prad_pkg::HANDLER_SLOTS_DEF
) (
    input  prad_pkg::req_t req,
    output prad_pkg::op_t  op
);
    import prad_pkg::*;

    localparam int PW = $clog2(PAGE_COUNT);

    logic [PW-1:0]    pmod_tab [256];
    logic [HID_W-1:0] hmod_tab [32];

    // Constant reduction tables: page number and handler id modulo their counts
    for (genvar g = 0; g < 256; g++) begin : g_pmod
        assign pmod_tab[g] = PW'(g % PAGE_COUNT);
    end
    for (genvar h = 0; h < 32; h++) begin : g_hmod
        assign hmod_tab[h] = HID_W'(h % HANDLER_SLOTS);
    end

    logic [5:0] k;
    logic       map_bad;
    logic       base_bad;
    logic [9:0] mirror_top;
    logic       mirror_bad;
    logic       overlap;

    always_comb
    begin
        k          = mask_shift(req.block_mask);
        map_bad    = (req.start_page > req.end_page)
                     || ({1'b0, req.end_page} >= 9'(PAGE_COUNT));
        base_bad   = (req.block_base[7:0] != 8'd0) || (req.block_base == 48'd0);
        mirror_top = {2'b00, req.start_page} + {1'b0, req.region_pages};
        mirror_bad = (req.region_pages == 9'd0) || (mirror_top > 10'(PAGE_COUNT));
        overlap    = (req.region_pages == 9'd1) && (req.dest_page == req.start_page);

        op            = '0;
        op.kind       = OP_REPORT;
        op.status     = ST_OK;
        op.addr       = req.addr;
        op.size_code  = req.size_code;
        op.is_write   = req.is_write;
        op.write_data = req.write_data;
        op.page       = req.start_page;
        op.last_page  = req.end_page;
        op.dest       = PAGE_FIELD_W'(pmod_tab[req.dest_page]);
        op.count      = req.region_pages;

        unique case (req.cmd) inside
            CMD_ACCESS:
            begin
                op.kind = OP_ACCESS;
                op.page = PAGE_FIELD_W'(pmod_tab[req.addr[PAGE_SHIFT +: PAGE_FIELD_W]]);
            end
            CMD_MAP_HANDLER, CMD_MAP_BLOCK:
            begin
                if (map_bad) begin
                    op.status = ST_BAD_RANGE;
                end else if (req.cmd == CMD_MAP_BLOCK && base_bad) begin
                    op.status = ST_BAD_BASE;
                end else if (req.cmd == CMD_MAP_BLOCK && k[5]) begin
                    op.status = ST_BAD_MASK;
                end else begin
                    op.kind  = OP_FILL;
                    op.entry = (req.cmd == CMD_MAP_HANDLER)
                               ? ENTRY_W'(hmod_tab[req.handler_num])
                               : {req.block_base[47:8], k[4:0]};
                end
            end
            CMD_MIRROR:
            begin
                if (mirror_bad) begin
                    op.status = ST_BAD_RANGE;
                end else if (overlap) begin
                    op.status = ST_OVERLAP;
                end else begin
                    op.kind = OP_MIRROR;
                end
            end
            default:
            begin
                op.kind = OP_REPORT;
            end
        endcase
    end

endmodule

// ===== hw/rtl/prad_queue.sv =====
// Short queue of decoded operations between the front and back parts.
// Depends on prad_pkg.
module prad_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  prad_pkg::op_t  push_op,
    output logic           full,
    input  logic           pop,
    output prad_pkg::op_t  head,
    output logic           empty
);
    import prad_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);

    op_t           slot_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0] level_reg, level_next;

    assign full  = (level_reg == LW'(QUEUE_DEPTH));
    assign empty = (level_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== hw/rtl/prad_back.sv =====
// Back part: owns the page table, carries out accesses, fills and mirrors,
// and holds the output register. Depends on prad_pkg.
module prad_back #(
    parameter int PAGE_COUNT = prad_pkg::PAGE_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  prad_pkg::op_t  head,
    input  logic           empty,
    output logic           pop,
    input  logic           out_stall,
    output logic           out_valid,
    output prad_pkg::res_t result
);
    import prad_pkg::*;

    localparam int PW = $clog2(PAGE_COUNT);

    back_state_t state_reg, state_next;
    op_t         op_reg, op_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] dst_reg, dst_next;
    logic [8:0]    left_reg, left_next;
    logic          out_valid_reg, out_valid_next;
    res_t          out_reg, out_next;
    logic          out_load;
    logic          out_free;

    logic [ENTRY_W-1:0]    page_mem [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] valid_reg;
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  rd_valid_reg;
    logic                  mem_re, mem_we;
    logic [PW-1:0]         mem_raddr, mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;

    logic [ENTRY_W-1:0] entry;
    logic [31:0]        masked;
    logic [47:0]        host;
    logic               split;
    res_t               first_piece, second_piece, report;

    assign out_valid = out_valid_reg;
    assign result    = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Result pieces built from the entry read for the current access
    always_comb
    begin
        entry  = rd_valid_reg ? rd_data_reg : '0;
        masked = op_reg.addr & (WORD_MASK >> entry[HID_W-1:0]);
        host   = {entry[ENTRY_W-1:HID_W], 8'd0} + {16'd0, masked};
        split  = (entry[ENTRY_W-1:HID_W] == '0) && (op_reg.size_code == SIZE_8B);

        first_piece              = '0;
        first_piece.status       = ST_OK;
        first_piece.access_write = op_reg.is_write;
        first_piece.last         = 1'b1;
        if (entry[ENTRY_W-1:HID_W] != '0) begin
            first_piece.to_memory    = 1'b1;
            first_piece.host_address = host;
            first_piece.handler_size = op_reg.size_code;
            first_piece.piece_data   = op_reg.is_write ? op_reg.write_data : 64'd0;
        end else if (split) begin
            first_piece.route_handler   = entry[HID_W-1:0];
            first_piece.handler_address = op_reg.addr;
            first_piece.handler_size    = SIZE_4B;
            first_piece.piece_data      = op_reg.is_write
                                          ? {32'd0, op_reg.write_data[31:0]} : 64'd0;
            first_piece.last            = 1'b0;
        end else begin
            first_piece.route_handler   = entry[HID_W-1:0];
            first_piece.handler_address = op_reg.addr;
            first_piece.handler_size    = op_reg.size_code;
            first_piece.piece_data      = op_reg.is_write ? op_reg.write_data : 64'd0;
        end

        second_piece                 = '0;
        second_piece.status          = ST_OK;
        second_piece.route_handler   = entry[HID_W-1:0];
        second_piece.handler_address = op_reg.addr + 32'd4;
        second_piece.handler_size    = SIZE_4B;
        second_piece.access_write    = op_reg.is_write;
        second_piece.piece_data      = op_reg.is_write
                                       ? {32'd0, op_reg.write_data[63:32]} : 64'd0;
        second_piece.last            = 1'b1;

        report        = '0;
        report.last   = 1'b1;
        report.status = op_reg.status;
    end

    // Sequencer: next state, table port controls and output loading
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        dst_next   = dst_reg;
        left_next  = left_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        out_next   = out_reg;
        mem_re     = 1'b0;
        mem_raddr  = cnt_reg;
        mem_we     = 1'b0;
        mem_waddr  = cnt_reg;
        mem_wdata  = op_reg.entry;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty) begin
                    pop     = 1'b1;
                    op_next = head;
                    unique case (head.kind)
                        OP_ACCESS:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = head.page[PW-1:0];
                            state_next = B_READ;
                        end
                        OP_FILL:
                        begin
                            cnt_next   = head.page[PW-1:0];
                            state_next = B_FILL;
                        end
                        OP_MIRROR:
                        begin
                            cnt_next   = head.page[PW-1:0];
                            dst_next   = head.dest[PW-1:0];
                            left_next  = head.count;
                            state_next = B_MREAD;
                        end
                        default:
                        begin
                            state_next = B_DONE;
                        end
                    endcase
                end
            end
            B_READ:
            begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_next   = first_piece;
                    state_next = split ? B_EMIT2 : B_IDLE;
                end
            end
            B_EMIT2:
            begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_next   = second_piece;
                    state_next = B_IDLE;
                end
            end
            B_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = op_reg.entry;
                if (cnt_reg == op_reg.last_page[PW-1:0]) begin
                    state_next = B_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            B_MREAD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = cnt_reg;
                state_next = B_MWRITE;
            end
            B_MWRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = dst_reg;
                mem_wdata = rd_valid_reg ? rd_data_reg : '0;
                cnt_next  = cnt_reg + 1'b1;
                dst_next  = (dst_reg == PW'(PAGE_COUNT - 1)) ? '0 : dst_reg + 1'b1;
                left_next = left_reg - 1'b1;
                state_next = (left_reg == 9'd1) ? B_DONE : B_MREAD;
            end
            B_DONE:
            begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_next   = report;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (mem_we) begin
                valid_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        cnt_reg  <= cnt_next;
        dst_reg  <= dst_next;
        left_reg <= left_next;
        out_reg  <= out_next;
    end

    // Page table memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            page_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg  <= page_mem[mem_raddr];
            rd_valid_reg <= valid_reg[mem_raddr];
        end
    end

endmodule

// ===== hw/rtl/page_region_address_decoder_top.sv =====
// Top level of the page region address decoder.
// Depends on prad_pkg, prad_front, prad_queue and prad_back.
//
// Usage
//  - Input channel (in_valid / in_stall): one item carries a command, either
//    an access to decode or a table command (map handler range, map block
//    range, mirror range). An item is taken when in_valid is high and
//    in_stall is low; in_stall rises only while the two-entry queue is full.
//  - Output channel (out_valid / out_stall): one result per item, two for an
//    8-byte handler access (low word first, last marks the final piece).
//    A result is taken when out_valid is high and out_stall is low; while
//    stalled the output register holds its value and the queue keeps filling.
//  - Path: an access passes a queue slot, the table read register and the
//    output register to its first result when nothing waits ahead of it.
//  - Sequencing: the back part finishes one item before it takes another; an
//    access reads the table, then emits, plus a step for the upper word of a
//    split access; a map command writes one page per step, a mirror reads
//    then writes each page; both then report. A failed command only reports.
//  - Reset (rst_n low, asynchronous): queue and output empty, and every page
//    reads as handler 0 through per-entry valid bits, so no clearing pass.
module page_region_address_decoder_top #(
    parameter int PAGE_COUNT    = prad_pkg::PAGE_COUNT_DEF,
    parameter int HANDLER_SLOTS = prad_pkg::HANDLER_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] addr,
    input  logic [1:0]  size_code,
    input  logic        is_write,
    input  logic [63:0] write_data,
    input  logic [7:0]  start_page,
    input  logic [7:0]  end_page,
    input  logic [8:0]  region_pages,
    input  logic [7:0]  dest_page,
    input  logic [4:0]  handler_num,
    input  logic [47:0] block_base,
    input  logic [31:0] block_mask,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        to_memory,
    output logic [47:0] host_address,
    output logic [4:0]  route_handler,
    output logic [31:0] handler_address,
    output logic [1:0]  handler_size,
    output logic        access_write,
    output logic [63:0] piece_data,
    output logic        last,
    output logic [2:0]  status
);
    import prad_pkg::*;

    req_t req;
    op_t  front_op;
    op_t  head_op;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic push;
    res_t result;

    // Gather the input fields into one request
    always_comb
    begin
        req.cmd          = cmd_t'(cmd);
        req.addr         = addr;
        req.size_code    = size_code;
        req.is_write     = is_write;
        req.write_data   = write_data;
        req.start_page   = start_page;
        req.end_page     = end_page;
        req.region_pages = region_pages;
        req.dest_page    = dest_page;
        req.handler_num  = handler_num;
        req.block_base   = block_base;
        req.block_mask   = block_mask;
    end

    // Hold the input side only while the queue has no free slot
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    prad_front #(
        .PAGE_COUNT    (PAGE_COUNT),
        .HANDLER_SLOTS (HANDLER_SLOTS)
    ) u_front (
        .req (req),
        .op  (front_op)
    );

    prad_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (front_op),
        .full    (q_full),
        .pop     (q_pop),
        .head    (head_op),
        .empty   (q_empty)
    );

    prad_back #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_op),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .result    (result)
    );

    assign to_memory       = result.to_memory;
    assign host_address    = result.host_address;
    assign route_handler   = result.route_handler;
    assign handler_address = result.handler_address;
    assign handler_size    = result.handler_size;
    assign access_write    = result.access_write;
    assign piece_data      = result.piece_data;
    assign last            = result.last;
    assign status          = result.status;

endmodule

// ===== hw/rtl/prad_checker.sv =====
// Port-level checks of the page region address decoder and their binding.
// Depends on prad_pkg and page_region_address_decoder_top.
module prad_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        to_memory,
    input logic [47:0] host_address,
    input logic [4:0]  route_handler,
    input logic [31:0] handler_address,
    input logic [1:0]  handler_size,
    input logic        access_write,
    input logic [63:0] piece_data,
    input logic        last,
    input logic [2:0]  status
);
    import prad_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(to_memory)
            && $stable(host_address) && $stable(route_handler)
            && $stable(handler_address) && $stable(handler_size)
            && $stable(access_write) && $stable(piece_data) && $stable(last)
            && $stable(status))
        else $error("stalled result changed");

    // First half of a split access is followed at once by its upper word
    a_split_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && last
            && handler_address == 32'($past(handler_address) + 32'd4))
        else $error("split access lost its second piece");

    // Only a split handler access produces a non-final piece
    a_split_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !to_memory && handler_size == SIZE_4B && status == ST_OK)
        else $error("non-final piece is not a 4-byte handler piece");

    // Memory accesses and failed commands are single results
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (to_memory || status != ST_OK) |-> last)
        else $error("single result without last");

endmodule

bind page_region_address_decoder_top prad_checker u_prad_checker (.*);
